// ===== design/u8sd_pkg.sv =====
// shared constants, types and helpers for the utf-8 stream decoder
`timescale 1ns / 1ps
package u8sd_pkg;

   localparam int unsigned MAX_STRING_BYTES = 65536;

   localparam int CP_W   = 21;
   localparam int CNT_W  = 17;
   localparam int BYTE_W = 8;
   localparam int RSP_W  = 56;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STRING_BYTES);

   localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
   localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h7F;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

   typedef logic [CNT_W-1:0] count_type;
   typedef logic [CP_W-1:0]  code_type;

   typedef struct packed {
      code_type  code_point;
      count_type start_offset;
      count_type char_count;
      logic      error;
      logic      end_of_run;
   } result_type;

   // sequence length from the lead byte alone, 1 to 4
   function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
      logic [2:0] len;
      if (b < LEAD_TWO) begin
         len = 3'd1;
      end else if (b < LEAD_THREE) begin
         len = 3'd2;
      end else if (b < LEAD_FOUR) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic count_type sat_inc(input count_type v);
      count_type r;
      if (v >= CNT_MAX) begin
         r = CNT_MAX;
      end else begin
         r = v + count_type'(1);
      end
      return r;
   endfunction

endpackage

// ===== design/utf8_stream_decoder.sv =====
// utf-8 stream decoder top level
`timescale 1ns / 1ps
// Usage: raw string bytes enter on the req_ channel, one word per byte, with
// req_tlast on the final byte of each string. Each completed character comes
// out on the rsp_ channel with its code point, its 1-based start offset and
// the running character count; rsp_tuser flags a malformed or truncated
// sequence, after which the rest of that string is dropped with no result.
// rsp_tlast marks the final result of a string (always set with an error).
// Throughput: one byte per cycle. All decoding is done in one pass of small
// mask, shift and compare logic between the accepted byte and the output
// register, so a result appears in the cycle after its last byte is accepted.
// Bytes that complete nothing (lead and middle bytes not ending the string,
// discarded bytes) produce no word.
// Stall: the output register holds its word while rsp_tready is low; a new
// byte is still taken whenever the output register is empty or being read
// in the same cycle.
// Reset: synchronous, active high; clears the decoder state (no pending
// sequence, byte position and character count at zero, character start at
// one) and empties the output register.
module utf8_stream_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   req_tlast,   // last_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [u8sd_pkg::RSP_W-1:0] rsp_tdata, // [20:0] code_point,
                                                 // [37:21] start_offset,
                                                 // [54:38] char_count, [55] zero
   output logic                   rsp_tuser,   // error
   output logic                   rsp_tlast    // end_of_run
);
   import u8sd_pkg::*;

   logic [1:0] bytes_left_ff, bytes_left_in;
   code_type   partial_ff, partial_in;
   count_type  byte_pos_ff, byte_pos_in;
   count_type  char_start_ff, char_start_in;
   count_type  chars_done_ff, chars_done_in;
   logic       discard_ff, discard_in;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic       accept;
   logic       emit;
   logic [2:0] len;
   count_type  pos_inc;
   count_type  chars_inc;
   code_type   shifted;
   logic       new_str;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign len       = lead_len(req_tdata);
   assign pos_inc   = sat_inc(byte_pos_ff);
   assign chars_inc = sat_inc(chars_done_ff);
   assign shifted   = {partial_ff[CP_W-7:0], 6'(req_tdata & CONT_BITS)};

   always_comb begin
      bytes_left_in = bytes_left_ff;
      partial_in    = partial_ff;
      byte_pos_in   = byte_pos_ff;
      char_start_in = char_start_ff;
      chars_done_in = chars_done_ff;
      discard_in    = discard_ff;
      emit          = 1'b0;
      new_str       = 1'b0;
      rsp_in        = rsp_ff;

      if (accept) begin
         byte_pos_in = pos_inc;
         if (discard_ff) begin
            new_str = req_tlast;
         end else if (bytes_left_ff == 2'd0) begin
            char_start_in = pos_inc;
            if (len == 3'd1) begin
               chars_done_in = chars_inc;
               emit          = 1'b1;
               rsp_in        = '{code_point: CP_W'(req_tdata), start_offset: pos_inc,
                                 char_count: chars_inc, error: 1'b0,
                                 end_of_run: req_tlast};
               new_str       = req_tlast;
            end else begin
               partial_in    = CP_W'(req_tdata & (PAYLOAD_MASK >> len));
               bytes_left_in = 2'(len - 3'd1);
               if (req_tlast) begin
                  emit    = 1'b1;
                  rsp_in  = '{code_point: '0, start_offset: pos_inc,
                              char_count: chars_done_ff, error: 1'b1,
                              end_of_run: 1'b1};
                  new_str = 1'b1;
               end
            end
         end else if ((req_tdata & CONT_MASK) != CONT_TAG) begin
            emit   = 1'b1;
            rsp_in = '{code_point: '0, start_offset: char_start_ff,
                       char_count: chars_done_ff, error: 1'b1, end_of_run: 1'b1};
            if (req_tlast) begin
               new_str = 1'b1;
            end else begin
               discard_in    = 1'b1;
               bytes_left_in = 2'd0;
               partial_in    = '0;
            end
         end else begin
            partial_in    = shifted;
            bytes_left_in = bytes_left_ff - 2'd1;
            if (bytes_left_ff == 2'd1) begin
               chars_done_in = chars_inc;
               partial_in    = '0;
               emit          = 1'b1;
               rsp_in        = '{code_point: shifted, start_offset: char_start_ff,
                                 char_count: chars_inc, error: 1'b0,
                                 end_of_run: req_tlast};
               new_str       = req_tlast;
            end else if (req_tlast) begin
               emit    = 1'b1;
               rsp_in  = '{code_point: '0, start_offset: char_start_ff,
                           char_count: chars_done_ff, error: 1'b1, end_of_run: 1'b1};
               new_str = 1'b1;
            end
         end

         if (new_str) begin
            bytes_left_in = 2'd0;
            partial_in    = '0;
            byte_pos_in   = '0;
            char_start_in = count_type'(1);
            chars_done_in = '0;
            discard_in    = 1'b0;
         end
      end

      // output register: load on a new result, drain when taken
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 2'd0;
         partial_ff    <= '0;
         byte_pos_ff   <= '0;
         char_start_ff <= count_type'(1);
         chars_done_ff <= '0;
         discard_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         partial_ff    <= partial_in;
         byte_pos_ff   <= byte_pos_in;
         char_start_ff <= char_start_in;
         chars_done_ff <= chars_done_in;
         discard_ff    <= discard_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.char_count, rsp_ff.start_offset, rsp_ff.code_point};
   assign rsp_tuser  = rsp_ff.error;
   assign rsp_tlast  = rsp_ff.end_of_run;

   // an error word always closes its string
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |-> rsp_ff.end_of_run)
      else $error("error word without end of run");

   // an error word carries no code point
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |-> rsp_ff.code_point == '0)
      else $error("error word with nonzero code point");

   // while dropping the rest of a string no sequence is pending
   a_discard_idle: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> bytes_left_ff == 2'd0 && partial_ff == '0)
      else $error("pending sequence while discarding");

   // a final byte clears the byte position, character count, pending sequence and discard flag
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> byte_pos_ff == '0 && chars_done_ff == '0
         && bytes_left_ff == 2'd0 && !discard_ff)
      else $error("string state not cleared after last byte");

endmodule

// ===== tb/sv/tb_utf8_stream_decoder.sv =====
// testbench for the utf-8 stream decoder: random and directed strings, scoreboard check
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
   import u8sd_pkg::*;

   typedef logic [7:0] byte_q_type[$];

   // tracks the decoder state and holds the characters it should emit, oldest first
   class utf8_scoreboard;
      result_type expected_q[$];
      logic [1:0] bytes_left;
      code_type   partial;
      count_type  byte_pos;
      count_type  char_start;
      count_type  chars_done;
      logic       discarding;
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned error_words;

      function new();
         clear_string();
         mismatches = 0;
         results_checked = 0;
         error_words = 0;
      endfunction

      function void clear_string();
         bytes_left = 2'd0;
         partial = '0;
         byte_pos = '0;
         char_start = count_type'(1);
         chars_done = '0;
         discarding = 1'b0;
      endfunction

      function count_type bump(input count_type v);
         if (v >= CNT_MAX) begin
            return CNT_MAX;
         end
         return v + count_type'(1);
      endfunction

      function void add_char(input code_type cp, input logic err, input logic eor);
         result_type r;
         r.code_point = cp;
         r.start_offset = char_start;
         r.char_count = chars_done;
         r.error = err;
         r.end_of_run = eor;
         expected_q.push_back(r);
      endfunction

      function void note_byte(input logic [7:0] b, input logic last);
         logic [2:0] seq_len;
         byte_pos = bump(byte_pos);
         if (discarding) begin
            if (last) begin
               clear_string();
            end
            return;
         end
         if (bytes_left == 2'd0) begin
            if (b < LEAD_TWO) begin
               seq_len = 3'd1;
            end else if (b < LEAD_THREE) begin
               seq_len = 3'd2;
            end else if (b < LEAD_FOUR) begin
               seq_len = 3'd3;
            end else begin
               seq_len = 3'd4;
            end
            char_start = byte_pos;
            if (seq_len == 3'd1) begin
               chars_done = bump(chars_done);
               add_char(code_type'(b), 1'b0, last);
               if (last) begin
                  clear_string();
               end
               return;
            end
            partial = code_type'(b & (PAYLOAD_MASK >> seq_len));
            bytes_left = 2'(seq_len - 3'd1);
            if (last) begin
               // string ends right on a multi-byte lead
               add_char('0, 1'b1, 1'b1);
               clear_string();
            end
            return;
         end
         if ((b & CONT_MASK) != CONT_TAG) begin
            add_char('0, 1'b1, 1'b1);
            if (last) begin
               clear_string();
            end else begin
               discarding = 1'b1;
               bytes_left = 2'd0;
               partial = '0;
            end
            return;
         end
         partial = (partial << 6) | code_type'(b & CONT_BITS);
         bytes_left = bytes_left - 2'd1;
         if (bytes_left == 2'd0) begin
            chars_done = bump(chars_done);
            add_char(partial, 1'b0, last);
            partial = '0;
            if (last) begin
               clear_string();
            end
            return;
         end
         if (last) begin
            add_char('0, 1'b1, 1'b1);
            clear_string();
         end
      endfunction

      function void check_word(input logic [RSP_W-1:0] data, input logic err,
                               input logic eor);
         result_type exp;
         code_type   got_cp;
         count_type  got_start;
         count_type  got_count;
         got_cp = data[CP_W-1:0];
         got_start = data[CP_W +: CNT_W];
         got_count = data[CP_W+CNT_W +: CNT_W];
         results_checked++;
         if (expected_q.size() == 0) begin
            $error("unexpected word: code_point %0h start_offset %0d char_count %0d",
                   got_cp, got_start, got_count);
            mismatches++;
            return;
         end
         exp = expected_q.pop_front();
         if (exp.error) begin
            error_words++;
         end
         if (got_cp !== exp.code_point) begin
            $error("code_point: expected %0h, got %0h", exp.code_point, got_cp);
            mismatches++;
         end
         if (got_start !== exp.start_offset) begin
            $error("start_offset: expected %0d, got %0d", exp.start_offset, got_start);
            mismatches++;
         end
         if (got_count !== exp.char_count) begin
            $error("char_count: expected %0d, got %0d", exp.char_count, got_count);
            mismatches++;
         end
         if (err !== exp.error) begin
            $error("error: expected %0b, got %0b", exp.error, err);
            mismatches++;
         end
         if (eor !== exp.end_of_run) begin
            $error("end_of_run: expected %0b, got %0b", exp.end_of_run, eor);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   localparam int HOLD_CYCLES = 300;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = 8'h00;
   logic             req_tlast = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   utf8_scoreboard sb = new();
   bit          calm = 1'b0;
   bit          stall_req = 1'b0;
   int unsigned bytes_sent = 0;
   int unsigned strings_sent = 0;

   utf8_stream_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // receiver: random stalls, or a long hold-off when asked for one
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_req) begin
            stall_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 18);
         end
      end
   end

   // called at a falling edge, returns at a falling edge with the word still offered
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_string(input byte_q_type s);
      foreach (s[i]) begin
         send_byte(s[i], i == s.size() - 1);
      end
      strings_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // mostly well-formed strings with random content, some corrupted, cut short or pure noise
   function automatic byte_q_type make_string();
      byte_q_type  s;
      int unsigned kind;
      int unsigned seq_len;
      int unsigned pos;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 16)) s.push_back(8'($urandom));
         return s;
      end
      repeat ($urandom_range(1, 12)) begin
         seq_len = $urandom_range(1, 4);
         case (seq_len)
            1: begin
               s.push_back(8'($urandom_range(8'h00, 8'h7F)));
            end
            2: begin
               s.push_back(8'($urandom_range(8'h80, 8'hDF)));
            end
            3: begin
               s.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            end
            default: begin
               s.push_back(8'($urandom_range(8'hF0, 8'hFF)));
            end
         endcase
         repeat (seq_len - 1) s.push_back({2'b10, 6'($urandom)});
      end
      if (kind < 20 && s.size() > 1) begin
         pos = $urandom_range(1, s.size() - 1);
         s[pos] = 8'($urandom);
      end else if (kind < 30 && s.size() > 2) begin
         repeat ($urandom_range(1, 2)) s.delete(s.size() - 1);
      end
      return s;
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings
      send_string('{8'h00});
      send_string('{8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF, 8'hFF, 8'hBF, 8'hBF, 8'hBF});
      send_string('{8'h80, 8'h80});          // stray continuation taken as a lead
      send_string('{8'hC3, 8'h41, 8'h42});   // bad continuation, rest dropped
      send_string('{8'h41, 8'hE2, 8'h82});   // string ends mid-sequence
      send_string('{8'hC3, 8'h00});          // bad continuation that is also last
      send_string('{8'hF0});                 // lone lead as the whole string
      drain();

      while (bytes_sent < 600) send_string(make_string());

      // long receiver hold-off while bytes keep coming
      stall_req = 1'b1;
      while (bytes_sent < 750) send_string(make_string());
      drain();

      calm = 1'b1;
      while (bytes_sent < 1200) send_string(make_string());
      calm = 1'b0;
      while (bytes_sent < 1750) send_string(make_string());

      drain();
      repeat (20) @(negedge clock);
      $display("%0d bytes in %0d strings drove %0d checked words, %0d of them error words",
               bytes_sent, strings_sent, sb.results_checked, sb.error_words);
      $display("covered all lead lengths, stray leads, bad and cut-off sequences, stalls");
      if (sb.mismatches == 0) begin
         $display("utf8_stream_decoder test passed");
      end else begin
         $display("utf8_stream_decoder test failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("utf8_stream_decoder test failed");
      $finish;
   end

endmodule

// ===== utf8_stream_decoder.f =====
design/u8sd_pkg.sv
design/utf8_stream_decoder.sv
tb/sv/tb_utf8_stream_decoder.sv
